/* rtl/pws_pkg.sv */
// ----------------------------------------------------------------------------
// pws_pkg
// Shared types, constants and helpers for the packet window statistics core.
// ----------------------------------------------------------------------------
package pws_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int QUEUE_DEPTH    = 2;

    localparam int WSIZE_W = 7;
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd8;

    localparam int TS_SEC_W  = 32;
    localparam int TS_USEC_W = 20;
    localparam int WNUM_W    = 32;

    // shared divider width: covers duration and all scaled dividends
    localparam int DIV_W = 52;

    localparam logic [19:0] USEC_PER_SEC   = 20'd1000000;
    localparam logic [27:0] RATE_SCALE     = 28'd256000000;   // 256 * 1e6
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  ETH_HDR_BYTES  = 8'd14;
    localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
    localparam int          ACK_BIT        = 4;

    typedef enum logic
    {
        REQ_PACKET = 1'b0,
        REQ_FLUSH  = 1'b1
    } req_t;

    typedef enum logic [2:0]
    {
        B_IDLE,
        B_MUL,
        B_DUR,
        B_AVG,
        B_GAP,
        B_RATE
    } back_state_t;

    // input item, captured_len in the lowest bits, pad in the highest
    typedef struct packed
    {
        logic [3:0]  pad;
        logic [7:0]  tcp_flag_bits;
        logic [3:0]  tcp_offset_words;
        logic [7:0]  ip_protocol;
        logic [3:0]  ip_header_words;
        logic [15:0] eth_type;
        logic [19:0] ts_micros;
        logic [31:0] ts_seconds;
        logic [15:0] wire_len;
        logic [15:0] captured_len;
    } pws_item_t;

    // result item, window_number in the lowest bits, pad in the highest
    typedef struct packed
    {
        logic [1:0]  pad;
        logic [33:0] rate_q8;
        logic [6:0]  ack_total;
        logic [51:0] mean_gap_us;
        logic [51:0] duration_us;
        logic [23:0] avg_size_q8;
        logic [21:0] byte_total;
        logic [6:0]  packet_total;
        logic [31:0] window_number;
    } pws_result_t;

    function automatic int cnt_width(input int max_window);
        return $clog2(max_window + 1);
    endfunction

    // window record: number, count, bytes, acks, first and last timestamps
    function automatic int rec_width(input int cnt_w);
        return WNUM_W + cnt_w + (16 + cnt_w) + cnt_w + 2 * (TS_SEC_W + TS_USEC_W);
    endfunction

endpackage

/* rtl/pws_queue.sv */
// ----------------------------------------------------------------------------
// pws_queue
// Short register FIFO carrying closed-window records from front to back end.
// ----------------------------------------------------------------------------
module pws_queue
    import pws_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH    // at least 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(DEPTH)) || pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue underflow");

endmodule

/* rtl/pws_div.sv */
// ----------------------------------------------------------------------------
// pws_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pws_div
    import pws_pkg::*;
#(
    parameter int W = DIV_W
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [W:0]       rem_reg,  rem_next;
    logic [W-1:0]     quo_reg,  quo_next;
    logic [W-1:0]     den_reg,  den_next;
    logic [W:0]       shifted;
    logic [W:0]       trial;

    always_comb
    begin
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        trial     = shifted - {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

/* rtl/pws_front.sv */
// ----------------------------------------------------------------------------
// pws_front
// Takes packet and flush transfers, classifies TCP ACKs and accumulates the
// open window; pushes one record per closed window.
// ----------------------------------------------------------------------------
module pws_front
    import pws_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int REC_W      = rec_width(cnt_width(MAX_WINDOW))
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [WSIZE_W-1:0] cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  req_t               req_type,
    input  pws_item_t          item,
    output logic               push,
    output logic [REC_W-1:0]   push_data
);

    localparam int CNT_W  = cnt_width(MAX_WINDOW);
    localparam int BYTE_W = 16 + CNT_W;

    typedef struct packed
    {
        logic [WNUM_W-1:0]    wnum;
        logic [CNT_W-1:0]     n;
        logic [BYTE_W-1:0]    bytes;
        logic [CNT_W-1:0]     acks;
        logic [TS_SEC_W-1:0]  first_sec;
        logic [TS_USEC_W-1:0] first_usec;
        logic [TS_SEC_W-1:0]  last_sec;
        logic [TS_USEC_W-1:0] last_usec;
    } rec_t;

    logic [WSIZE_W-1:0]   wsize_reg;
    logic [CNT_W-1:0]     count_reg,      count_next;
    logic [BYTE_W-1:0]    bytes_reg,      bytes_next;
    logic [CNT_W-1:0]     acks_reg,       acks_next;
    logic [TS_SEC_W-1:0]  first_sec_reg,  first_sec_next;
    logic [TS_USEC_W-1:0] first_usec_reg, first_usec_next;
    logic [TS_SEC_W-1:0]  last_sec_reg,   last_sec_next;
    logic [TS_USEC_W-1:0] last_usec_reg,  last_usec_next;
    logic [WNUM_W-1:0]    wnum_reg,       wnum_next;

    logic                 accept;
    logic [CNT_W-1:0]     eff_size;
    logic [7:0]           hdr_bytes;
    logic                 is_ack;
    logic [CNT_W-1:0]     cnt_inc;
    logic [BYTE_W-1:0]    bytes_inc;
    logic [CNT_W-1:0]     acks_inc;
    rec_t                 rec;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        if (wsize_reg == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else if (32'(wsize_reg) > MAX_WINDOW)
        begin
            eff_size = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            eff_size = CNT_W'(wsize_reg);
        end
    end

    // headers must fit in what was captured
    assign hdr_bytes = ETH_HDR_BYTES + {2'b00, item.ip_header_words, 2'b00}
                     + {2'b00, item.tcp_offset_words, 2'b00};
    assign is_ack = (item.eth_type == ETHERTYPE_IPV4)
                 && (item.ip_header_words >= MIN_HDR_WORDS)
                 && (item.ip_protocol == PROTO_TCP)
                 && (item.tcp_offset_words >= MIN_HDR_WORDS)
                 && (item.captured_len >= 16'(hdr_bytes))
                 && item.tcp_flag_bits[ACK_BIT];

    assign cnt_inc   = count_reg + 1'b1;
    assign bytes_inc = bytes_reg + BYTE_W'(item.wire_len);
    assign acks_inc  = acks_reg + CNT_W'(is_ack);

    always_comb
    begin
        count_next      = count_reg;
        bytes_next      = bytes_reg;
        acks_next       = acks_reg;
        first_sec_next  = first_sec_reg;
        first_usec_next = first_usec_reg;
        last_sec_next   = last_sec_reg;
        last_usec_next  = last_usec_reg;
        wnum_next       = wnum_reg;
        push            = 1'b0;

        rec.wnum       = wnum_reg + 1'b1;
        rec.n          = count_reg;
        rec.bytes      = bytes_reg;
        rec.acks       = acks_reg;
        rec.first_sec  = first_sec_reg;
        rec.first_usec = first_usec_reg;
        rec.last_sec   = last_sec_reg;
        rec.last_usec  = last_usec_reg;

        if (accept)
        begin
            if (req_type == REQ_FLUSH)
            begin
                if (count_reg != '0)
                begin
                    push       = 1'b1;
                    count_next = '0;
                    bytes_next = '0;
                    acks_next  = '0;
                    wnum_next  = wnum_reg + 1'b1;
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    rec.first_sec  = item.ts_seconds;
                    rec.first_usec = item.ts_micros;
                end
                rec.n         = cnt_inc;
                rec.bytes     = bytes_inc;
                rec.acks      = acks_inc;
                rec.last_sec  = item.ts_seconds;
                rec.last_usec = item.ts_micros;

                first_sec_next  = rec.first_sec;
                first_usec_next = rec.first_usec;
                last_sec_next   = item.ts_seconds;
                last_usec_next  = item.ts_micros;
                // a lowered window size closes on the next packet
                if (cnt_inc >= eff_size)
                begin
                    push       = 1'b1;
                    count_next = '0;
                    bytes_next = '0;
                    acks_next  = '0;
                    wnum_next  = wnum_reg + 1'b1;
                end
                else
                begin
                    count_next = cnt_inc;
                    bytes_next = bytes_inc;
                    acks_next  = acks_inc;
                end
            end
        end
    end

    assign push_data = rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg      <= WSIZE_RESET;
            count_reg      <= '0;
            bytes_reg      <= '0;
            acks_reg       <= '0;
            first_sec_reg  <= '0;
            first_usec_reg <= '0;
            last_sec_reg   <= '0;
            last_usec_reg  <= '0;
            wnum_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                wsize_reg <= cfg_wdata;
            end
            count_reg      <= count_next;
            bytes_reg      <= bytes_next;
            acks_reg       <= acks_next;
            first_sec_reg  <= first_sec_next;
            first_usec_reg <= first_usec_next;
            last_sec_reg   <= last_sec_next;
            last_usec_reg  <= last_usec_next;
            wnum_reg       <= wnum_next;
        end
    end

    a_count_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) < MAX_WINDOW)
        else $error("open window reached max size without closing");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == REQ_FLUSH)) |=> (count_reg == '0) && (acks_reg == '0))
        else $error("flush left window open");

endmodule

/* rtl/pws_back.sv */
// ----------------------------------------------------------------------------
// pws_back
// Turns closed-window records into result items: duration, then average,
// mean gap and rate through one shared divider, into an output register.
// ----------------------------------------------------------------------------
module pws_back
    import pws_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int REC_W      = rec_width(cnt_width(MAX_WINDOW))
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rec_valid,
    input  logic [REC_W-1:0] rec_data,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output pws_result_t      out_data
);

    localparam int CNT_W  = cnt_width(MAX_WINDOW);
    localparam int BYTE_W = 16 + CNT_W;
    localparam int NR_W   = CNT_W + 28;

    typedef struct packed
    {
        logic [WNUM_W-1:0]    wnum;
        logic [CNT_W-1:0]     n;
        logic [BYTE_W-1:0]    bytes;
        logic [CNT_W-1:0]     acks;
        logic [TS_SEC_W-1:0]  first_sec;
        logic [TS_USEC_W-1:0] first_usec;
        logic [TS_SEC_W-1:0]  last_sec;
        logic [TS_USEC_W-1:0] last_usec;
    } rec_t;

    back_state_t        state_reg, state_next;
    rec_t               rec_reg;
    logic signed [53:0] prod_reg;
    logic [DIV_W-1:0]   nrate_reg;
    logic [DIV_W-1:0]   dur_reg;
    logic [DIV_W-1:0]   avg_reg;
    logic [DIV_W-1:0]   gap_reg;
    logic               out_valid_reg;
    pws_result_t        out_reg;

    logic signed [32:0] dsec;
    logic signed [20:0] usec_scale;
    logic signed [53:0] prod;
    logic signed [20:0] dusec;
    logic signed [53:0] diff;
    logic [DIV_W-1:0]   dur_clamped;
    logic [NR_W-1:0]    nrate;

    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic               div_busy;
    logic [DIV_W-1:0]   div_quotient;
    logic               out_free;
    logic               load_out;

    assign dsec       = $signed({1'b0, rec_reg.last_sec}) - $signed({1'b0, rec_reg.first_sec});
    assign usec_scale = $signed({1'b0, USEC_PER_SEC});
    assign prod       = dsec * usec_scale;
    assign nrate      = rec_reg.n * RATE_SCALE;
    assign dusec      = $signed({1'b0, rec_reg.last_usec})
                      - $signed({1'b0, rec_reg.first_usec});
    assign diff       = prod_reg + 54'(dusec);
    assign dur_clamped = (diff[53] || (diff == '0)) ? '0 : diff[DIV_W-1:0];

    assign out_free = !out_valid_reg || out_ready;

    pws_div #(
        .W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (rec_valid)
                begin
                    state_next = B_MUL;
                end
            end
            B_MUL:  state_next = B_DUR;
            B_DUR:  state_next = B_AVG;
            B_AVG:
            begin
                if (!div_busy)
                begin
                    state_next = B_GAP;
                end
            end
            B_GAP:
            begin
                if (!div_busy)
                begin
                    state_next = B_RATE;
                end
            end
            B_RATE:
            begin
                if (!div_busy && out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        pop          = 1'b0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        load_out     = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                pop = rec_valid;
            end
            B_MUL:
            begin
            end
            B_DUR:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({rec_reg.bytes, 8'h00});
                div_divisor  = DIV_W'(rec_reg.n);
            end
            B_AVG:
            begin
                div_start    = !div_busy;
                div_dividend = dur_reg;
                div_divisor  = DIV_W'(rec_reg.n - 1'b1);
            end
            B_GAP:
            begin
                div_start    = !div_busy;
                div_dividend = nrate_reg;
                div_divisor  = dur_reg;
            end
            B_RATE:
            begin
                load_out = !div_busy && out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg <= rec_data;
        end
        if (state_reg == B_MUL)
        begin
            prod_reg  <= prod;
            nrate_reg <= DIV_W'(nrate);
        end
        if (state_reg == B_DUR)
        begin
            dur_reg <= dur_clamped;
        end
        if ((state_reg == B_AVG) && !div_busy)
        begin
            avg_reg <= div_quotient;
        end
        if ((state_reg == B_GAP) && !div_busy)
        begin
            // one packet or zero duration has no gap
            gap_reg <= ((rec_reg.n > CNT_W'(1)) && (dur_reg != '0)) ? div_quotient : '0;
        end
        if (load_out)
        begin
            out_reg.pad           <= '0;
            out_reg.window_number <= rec_reg.wnum;
            out_reg.packet_total  <= 7'(rec_reg.n);
            out_reg.byte_total    <= 22'(rec_reg.bytes);
            out_reg.avg_size_q8   <= 24'(avg_reg);
            out_reg.duration_us   <= dur_reg;
            out_reg.mean_gap_us   <= gap_reg;
            out_reg.ack_total     <= 7'(rec_reg.acks);
            out_reg.rate_q8       <= (dur_reg != '0) ? 34'(div_quotient) : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

/* rtl/packet_window_stats_core.sv */
// ----------------------------------------------------------------------------
// packet_window_stats_core
// Groups packet metadata into windows and reports per-window statistics.
// ----------------------------------------------------------------------------
//  channel   dir  tdata / data                    tuser
//  s_axis    in   packet metadata (128 bits)      req_type: 0 packet, 1 flush
//  m_axis    out  window statistics (232 bits)    -
//  cfg       in   window size (7 bits)            -
//
//  The front end takes one transfer per cycle while its record queue has room.
//  Each closed window goes through the back end's multiply and duration steps,
//  then the one-bit-per-cycle divider shared by average, gap and rate. Windows
//  closing faster than they are served fill the two-entry queue and then stall
//  s_axis. The result register frees the back end while m_axis is stalled.
//  Reset is asynchronous; window size resets to 8, all counts to zero.
// ----------------------------------------------------------------------------
module packet_window_stats_core
    import pws_pkg::*;
#(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_we,
    input  logic [WSIZE_W-1:0] cfg_wdata,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // captured_len, wire_len, ts_seconds, ts_micros, eth_type,
    // ip_header_words, ip_protocol, tcp_offset_words, tcp_flag_bits, pad
    input  logic [127:0]       s_axis_tdata,
    // req_type
    input  logic [0:0]         s_axis_tuser,

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // window_number, packet_total, byte_total, avg_size_q8, duration_us,
    // mean_gap_us, ack_total, rate_q8, pad
    output logic [231:0]       m_axis_tdata
);

    localparam int CNT_W = cnt_width(MAX_WINDOW);
    localparam int REC_W = rec_width(CNT_W);

    logic             q_push;
    logic [REC_W-1:0] q_push_data;
    logic             q_full;
    logic             q_pop;
    logic             q_valid;
    logic [REC_W-1:0] q_head;
    pws_item_t        item;
    req_t             req_type;
    pws_result_t      result;

    assign item          = pws_item_t'(s_axis_tdata);
    assign req_type      = req_t'(s_axis_tuser[0]);
    assign s_axis_tready = !q_full;
    assign m_axis_tdata  = result;

    pws_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .REC_W      (REC_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .req_type  (req_type),
        .item      (item),
        .push      (q_push),
        .push_data (q_push_data)
    );

    pws_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    pws_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .REC_W      (REC_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (q_valid),
        .rec_data  (q_head),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

endmodule
